@@ rtl/core/dtm_pkg.sv @@
// Shared constants, types and helper functions of the descriptor threshold match block.
package dtm_pkg;

  // Vector length, number of model slots and sample width
  localparam int DIMENSION   = 128;
  localparam int MAX_MODELS  = 256;
  localparam int SAMPLE_BITS = 16;

  // Port widths fixed by the item format
  localparam int VALUE_W    = 16;
  localparam int SLOT_IN_W  = 8;
  localparam int POS_IN_W   = 7;
  localparam int SUM_W      = 41;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 1;

  // Derived widths
  localparam int IDX_W   = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
  localparam int SLOT_W  = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
  localparam int MDEPTH  = MAX_MODELS * DIMENSION;
  localparam int MADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int ADD_W   = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODELS = 1'b1;

  localparam logic [SUM_W-1:0] LIMIT_RESET = SUM_W'(24159191);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Tag that travels with each element read through the distance pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } scan_tag_t;

  // Take the low sample bits of the raw value as a two's complement sample
  function automatic sample_t to_sample(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W+SAMPLE_BITS-1:0] ext;
    ext = {{SAMPLE_BITS{1'b0}}, raw};
    return ext[SAMPLE_BITS-1:0];
  endfunction

  // Flat model store address of one element
  function automatic logic [MADDR_W-1:0] model_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [IDX_W-1:0] pos);
    return MADDR_W'(MADDR_W'(slot) * MADDR_W'(DIMENSION)) + MADDR_W'(pos);
  endfunction

endpackage

@@ rtl/core/descriptor_threshold_match.sv @@
// Top level of the descriptor threshold match: item decode, scan sequencer and result register.
//
// A load item writes one element of a reference vector into the model store and a query item
// writes one element into the query buffer. The query item at the last vector position starts a
// scan over slots 0 to min(models_in_use, 256) - 1 and the input is stalled until the scan ends.
// The model store has one read port delivering one element per cycle, so each slot scanned
// takes a read of every element plus the drain of the read, difference, square and accumulate
// pipeline; the scan stops at the first slot whose squared distance lies strictly below
// match_limit_sq. The single result is held in an output register until taken, and new items
// are accepted while it waits. Configuration is always ready and must be written only while
// the block is idle. The stores need no clearing after reset.
module descriptor_threshold_match (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [dtm_pkg::SLOT_IN_W-1:0]     in_slot,
  input  logic [dtm_pkg::POS_IN_W-1:0]      in_position,
  input  logic signed [dtm_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [dtm_pkg::SLOT_IN_W-1:0]     out_model_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dtm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dtm_pkg::SUM_W-1:0]         cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int IDX_W  = dtm_pkg::IDX_W;
  localparam int SLOT_W = dtm_pkg::SLOT_W;

  logic [1:0]                   state_r, state_nxt;
  logic [IDX_W-1:0]             elem_r, elem_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [SLOT_W-1:0]            last_slot_r, last_slot_nxt;
  logic                         found_r, found_nxt;
  logic [dtm_pkg::SUM_W-1:0]    limit_r;
  logic [dtm_pkg::COUNT_W-1:0]  models_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r;
  logic [dtm_pkg::SLOT_IN_W-1:0] out_index_r;

  logic                         in_acc;
  logic                         pos_ok, slot_ok;
  logic                         load_we, query_we, last_query;
  logic [IDX_W-1:0]             in_idx;
  logic [SLOT_W-1:0]            in_sidx;
  dtm_pkg::sample_t             in_smp;
  logic                         scan_rd;
  logic                         elem_last;
  logic                         result_ld;
  logic [dtm_pkg::MADDR_W-1:0]  m_waddr, m_raddr;
  dtm_pkg::sample_t             m_rdata, q_rdata;
  dtm_pkg::scan_tag_t           tag;
  logic [dtm_pkg::SUM_W-1:0]    dist_sum;
  logic                         dist_done;

  // Decode the input item
  always_comb begin
    in_acc     = in_valid & ~in_stall;
    pos_ok     = 32'(in_position) < dtm_pkg::DIMENSION;
    slot_ok    = 32'(in_slot) < dtm_pkg::MAX_MODELS;
    in_idx     = in_position[IDX_W-1:0];
    in_sidx    = in_slot[SLOT_W-1:0];
    in_smp     = dtm_pkg::to_sample(in_value);
    load_we    = in_acc & pos_ok & slot_ok & (in_op == dtm_pkg::OP_LOAD);
    query_we   = in_acc & pos_ok & (in_op == dtm_pkg::OP_QUERY);
    last_query = query_we & (in_position == dtm_pkg::POS_IN_W'(dtm_pkg::DIMENSION - 1));
    m_waddr    = dtm_pkg::model_addr(in_sidx, in_idx);
    m_raddr    = dtm_pkg::model_addr(slot_r, elem_r);
  end

  dtm_ram #(
    .WIDTH (dtm_pkg::SAMPLE_BITS),
    .DEPTH (dtm_pkg::MDEPTH),
    .ADDR_W(dtm_pkg::MADDR_W)
  ) u_model_store (
    .clk  (clk),
    .we   (load_we),
    .waddr(m_waddr),
    .wdata(in_smp),
    .re   (scan_rd),
    .raddr(m_raddr),
    .rdata(m_rdata)
  );

  dtm_ram #(
    .WIDTH (dtm_pkg::SAMPLE_BITS),
    .DEPTH (dtm_pkg::DIMENSION),
    .ADDR_W(IDX_W)
  ) u_query_buf (
    .clk  (clk),
    .we   (query_we),
    .waddr(in_idx),
    .wdata(in_smp),
    .re   (scan_rd),
    .raddr(elem_r),
    .rdata(q_rdata)
  );

  dtm_dist_acc u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (tag),
    .model_smp(m_rdata),
    .query_smp(q_rdata),
    .dist_sum (dist_sum),
    .dist_done(dist_done)
  );

  // Issue one element read per cycle while scanning
  always_comb begin
    scan_rd   = (state_r == ST_SCAN);
    elem_last = (elem_r == IDX_W'(dtm_pkg::DIMENSION - 1));
    tag.vld   = scan_rd;
    tag.first = (elem_r == '0);
    tag.last  = elem_last;
  end

  // Scan sequencer
  always_comb begin
    state_nxt     = state_r;
    elem_nxt      = elem_r;
    slot_nxt      = slot_r;
    last_slot_nxt = last_slot_r;
    found_nxt     = found_r;
    result_ld     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (last_query) begin
          elem_nxt  = '0;
          slot_nxt  = '0;
          found_nxt = 1'b0;
          if (models_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
            if (32'(models_r) >= dtm_pkg::MAX_MODELS) begin
              last_slot_nxt = SLOT_W'(dtm_pkg::MAX_MODELS - 1);
            end else begin
              last_slot_nxt = SLOT_W'(models_r - 1'b1);
            end
          end
        end
      end
      ST_SCAN: begin
        if (elem_last) begin
          elem_nxt  = '0;
          state_nxt = ST_CHECK;
        end else begin
          elem_nxt = elem_r + 1'b1;
        end
      end
      ST_CHECK: begin
        if (dist_done) begin
          if (dist_sum < limit_r) begin
            found_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (slot_r == last_slot_r) begin
            state_nxt = ST_DONE;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_DONE: begin
        // Hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          result_ld = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elem_r      <= '0;
      slot_r      <= '0;
      last_slot_r <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elem_r      <= elem_nxt;
      slot_r      <= slot_nxt;
      last_slot_r <= last_slot_nxt;
      found_r     <= found_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (result_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ld) begin
      out_found_r <= found_r;
      out_index_r <= found_r ? dtm_pkg::SLOT_IN_W'(slot_r) : '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= dtm_pkg::LIMIT_RESET;
      models_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtm_pkg::REG_LIMIT:  limit_r  <= cfg_data;
        dtm_pkg::REG_MODELS: models_r <= cfg_data[dtm_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready       = 1'b1;
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_model_index = out_index_r;

  // A new result appears only after the sequencer finished a scan
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside scan completion");

  // A miss reports slot zero
  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_model_index == '0))
    else $error("miss with non-zero model index");

  // Slot sums complete only while the sequencer waits for them
  a_done_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    dist_done |-> (state_r == ST_CHECK))
    else $error("slot sum completed outside check state");

  // Element counter rests at zero outside a read burst
  a_elem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (elem_r == '0))
    else $error("element counter not at zero outside scan");

endmodule

@@ rtl/core/dtm_ram.sv @@
// Single write port, single read port synchronous RAM with registered read data.
module dtm_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/dtm_dist_acc.sv @@
// Distance pipeline: absolute difference, square and saturating accumulation per slot.
module dtm_dist_acc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dtm_pkg::scan_tag_t        tag_in,
  input  dtm_pkg::sample_t          model_smp,
  input  dtm_pkg::sample_t          query_smp,
  output logic [dtm_pkg::SUM_W-1:0] dist_sum,
  output logic                      dist_done
);

  localparam int S = dtm_pkg::SAMPLE_BITS;

  dtm_pkg::scan_tag_t tag_a_r, tag_b_r, tag_c_r;
  logic [S-1:0]                 absd_r;
  logic [dtm_pkg::SQ_W-1:0]     sq_r;
  logic [dtm_pkg::SUM_W-1:0]    acc_r, acc_nxt;
  logic                         done_r;
  logic [S:0]                   diff;
  logic [S:0]                   absd;
  logic [dtm_pkg::ADD_W-1:0]    base;
  logic [dtm_pkg::ADD_W-1:0]    total;
  logic [dtm_pkg::ADD_W-1:0]    sum_max;

  // Align tags with RAM data and carry them down the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
      done_r  <= 1'b0;
      acc_r   <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
      done_r  <= tag_c_r.vld & tag_c_r.last;
      acc_r   <= acc_nxt;
    end
  end

  // Absolute difference of the two samples
  always_comb begin
    diff = {model_smp[S-1], model_smp} - {query_smp[S-1], query_smp};
    absd = diff[S] ? (~diff + 1'b1) : diff;
  end

  // Register the difference, then its square
  always_ff @(posedge clk) begin
    absd_r <= absd[S-1:0];
    sq_r   <= absd_r * absd_r;
  end

  // Accumulate with saturation; restart on the first element of a slot
  always_comb begin
    sum_max = dtm_pkg::ADD_W'({dtm_pkg::SUM_W{1'b1}});
    base    = tag_c_r.first ? '0 : dtm_pkg::ADD_W'(acc_r);
    total   = base + dtm_pkg::ADD_W'(sq_r);
    acc_nxt = acc_r;
    if (tag_c_r.vld) begin
      acc_nxt = (total > sum_max) ? {dtm_pkg::SUM_W{1'b1}} : total[dtm_pkg::SUM_W-1:0];
    end
  end

  assign dist_sum  = acc_r;
  assign dist_done = done_r;

endmodule

@@ tb/dtm_match_check_pkg.sv @@
// Result predictor and checker class for the descriptor threshold match testbench.
package dtm_match_check_pkg;
  import dtm_pkg::*;

  localparam longint unsigned SUM_CEIL = (64'd1 << SUM_W) - 64'd1;

  typedef struct packed {
    logic                 found;
    logic [SLOT_IN_W-1:0] index;
  } match_t;

  class match_checker;
    sample_t              model_mem [MDEPTH];
    sample_t              query_mem [DIMENSION];
    logic [SUM_W-1:0]     limit_sq;
    logic [COUNT_W-1:0]   models_used;
    logic [SUM_W-1:0]     last_sum;
    match_t               pending_matches [$];
    int                   errors;
    int                   results;
    int                   hits;

    function new();
      limit_sq    = LIMIT_RESET;
      models_used = '0;
      last_sum    = '0;
      errors      = 0;
      results     = 0;
      hits        = 0;
      foreach (model_mem[i]) model_mem[i] = '0;
      foreach (query_mem[i]) query_mem[i] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SUM_W-1:0] data);
      if (idx == REG_LIMIT) begin
        limit_sq = data;
      end else if (idx == REG_MODELS) begin
        models_used = data[COUNT_W-1:0];
      end
    endfunction

    // Sum of squared element differences between one stored model and the query
    function logic [SUM_W-1:0] squared_distance(int unsigned s);
      longint unsigned acc;
      longint          d;
      int unsigned     i;
      acc = 0;
      for (i = 0; i < DIMENSION; i++) begin
        d = longint'(model_mem[s * DIMENSION + i]) - longint'(query_mem[i]);
        acc += longint'(d * d);
        if (acc > SUM_CEIL) acc = SUM_CEIL;
      end
      return acc[SUM_W-1:0];
    endfunction

    // Apply one accepted item; the last query element queues the expected match
    function void take_item(logic op, logic [SLOT_IN_W-1:0] slot,
                            logic [POS_IN_W-1:0] pos, logic [VALUE_W-1:0] value);
      sample_t     smp;
      int unsigned n;
      int unsigned s;
      match_t      m;
      smp = value[SAMPLE_BITS-1:0];
      if (pos >= DIMENSION) return;
      if (op == OP_LOAD) begin
        if (slot < MAX_MODELS) model_mem[slot * DIMENSION + pos] = smp;
        return;
      end
      query_mem[pos] = smp;
      if (pos != DIMENSION - 1) return;
      n = (models_used > MAX_MODELS) ? MAX_MODELS : models_used;
      m.found = 1'b0;
      m.index = '0;
      for (s = 0; s < n; s++) begin
        last_sum = squared_distance(s);
        if (last_sum < limit_sq) begin
          m.found = 1'b1;
          m.index = SLOT_IN_W'(s);
          break;
        end
      end
      pending_matches = {pending_matches, m};
    endfunction

    // Compare one delivered result with the oldest expected match
    function void check_result(logic found, logic [SLOT_IN_W-1:0] index);
      match_t want;
      if (pending_matches.size() == 0) begin
        $display("%0t: result found=%0b model_index=%0d with none expected",
                 $time, found, index);
        errors++;
        return;
      end
      want = pending_matches.pop_front();
      results++;
      if (want.found) hits++;
      if (found !== want.found) begin
        $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, found);
        errors++;
      end
      if (index !== want.index) begin
        $display("%0t: model_index mismatch, expected %0d actual %0d",
                 $time, want.index, index);
        errors++;
      end
    endfunction

    // Count expected matches that never arrived
    function void close();
      if (pending_matches.size() != 0) begin
        $display("%0t: %0d expected results never delivered", $time, pending_matches.size());
        errors += pending_matches.size();
      end
    endfunction
  endclass

endpackage

@@ tb/descriptor_threshold_match_test.sv @@
// Testbench top of the descriptor threshold match: stimulus, handshakes and final verdict.
module descriptor_threshold_match_test;
  import dtm_pkg::*;
  import dtm_match_check_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_LOADED   = 16;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 20000000;
  localparam logic [SUM_W-1:0] LIMIT_MAX = '1;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      in_op       = OP_LOAD;
  logic [SLOT_IN_W-1:0]      in_slot     = '0;
  logic [POS_IN_W-1:0]       in_position = '0;
  logic signed [VALUE_W-1:0] in_value    = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic                      out_found;
  logic [SLOT_IN_W-1:0]      out_model_index;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index   = REG_LIMIT;
  logic [SUM_W-1:0]          cfg_data    = '0;

  match_checker sb;

  int  items_sent   = 0;
  int  loads_sent   = 0;
  int  queries_sent = 0;
  int  cfg_writes   = 0;
  int  cycles       = 0;
  int  loaded       = 0;
  bit  steady_in    = 1'b0;
  int  calm_left    = 0;
  int  stall_left   = 0;
  int  out_roll;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  descriptor_threshold_match i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_slot         (in_slot),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_model_index (out_model_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("descriptor_threshold_match_test: done, errors");
      $finish;
    end
  end

  // Check each taken result, then draw the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_result(out_found, out_model_index);
    end
    if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_roll = $urandom_range(0, 99);
      if (out_roll < 3) begin
        calm_left = $urandom_range(50, 400);
      end else if (out_roll < 30) begin
        stall_left = $urandom_range(1, 3);
      end else if (out_roll < 34) begin
        stall_left = $urandom_range(10, 60);
      end
    end
  end

  // Idle gap between items: mostly none or short, now and then long
  function automatic int draw_gap();
    int roll;
    if (steady_in) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Noise amplitude for element values
  function automatic int unsigned draw_amp();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return 0;
    if (roll < 60) return $urandom_range(1, 15);
    if (roll < 85) return $urandom_range(16, 600);
    return 32767;
  endfunction

  function automatic logic [VALUE_W-1:0] nudge(logic [VALUE_W-1:0] base, int unsigned amp);
    return base + VALUE_W'(int'($urandom_range(0, 2 * amp)) - int'(amp));
  endfunction

  // Limit spread over all magnitudes, with the extremes and the last distance boundary
  function automatic logic [SUM_W-1:0] random_limit();
    int               roll;
    logic [SUM_W-1:0] r;
    roll = $urandom_range(0, 99);
    r = SUM_W'({$urandom(), $urandom()});
    if (roll < 8) return '0;
    if (roll < 16) return LIMIT_MAX;
    if (roll < 24) return r;
    if (roll < 36) return sb.last_sum + SUM_W'($urandom_range(0, 1));
    return r & ((SUM_W'(1) << $urandom_range(1, SUM_W - 1)) - SUM_W'(1));
  endfunction

  // Model count word; bits above the register width carry junk at times
  function automatic logic [SUM_W-1:0] models_setting(int unsigned n);
    logic [SUM_W-1:0] w;
    w = SUM_W'({$urandom(), $urandom()});
    if ($urandom_range(0, 1) == 0) w = '0;
    w[COUNT_W-1:0] = COUNT_W'(n);
    return w;
  endfunction

  // Never search past the fully loaded slots
  function automatic int unsigned draw_models();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 25) return loaded;
    return $urandom_range(0, loaded);
  endfunction

  task automatic send_item(logic op, logic [SLOT_IN_W-1:0] slot, logic [POS_IN_W-1:0] pos,
                           logic [VALUE_W-1:0] value);
    int gap;
    in_valid    <= 1'b1;
    in_op       <= op;
    in_slot     <= slot;
    in_position <= pos;
    in_value    <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.take_item(op, slot, pos, value);
    items_sent++;
    if (op == OP_LOAD) loads_sent++;
    else queries_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [SUM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_register(idx, data);
    cfg_writes++;
  endtask

  // Write either register or both back to back, then release the port
  task automatic write_regs(bit do_limit, logic [SUM_W-1:0] limit, bit do_models,
                            logic [SUM_W-1:0] models_word);
    if (do_limit) put_reg(REG_LIMIT, limit);
    if (do_models) put_reg(REG_MODELS, models_word);
    if (do_limit || do_models) cfg_valid <= 1'b0;
  endtask

  // Hold the input idle until every expected result is in and the scan pipeline has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Fill a whole slot: around a fixed value, or around another loaded slot
  task automatic load_slot(int unsigned s, int src, int unsigned amp, logic [VALUE_W-1:0] fill);
    int unsigned p;
    for (p = 0; p < DIMENSION; p++) begin
      send_item(OP_LOAD, SLOT_IN_W'(s), POS_IN_W'(p),
                (src < 0) ? nudge(fill, amp) : nudge(sb.model_mem[src * DIMENSION + p], amp));
    end
  endtask

  // Deliver a whole query close to one stored model
  task automatic query_like(int unsigned s, int unsigned amp);
    int unsigned p;
    for (p = 0; p < DIMENSION; p++) begin
      send_item(OP_QUERY, SLOT_IN_W'($urandom()), POS_IN_W'(p),
                nudge(sb.model_mem[s * DIMENSION + p], amp));
    end
  endtask

  // Change a few query elements, then close the vector to start a scan
  task automatic touch_query();
    int unsigned k;
    int unsigned p;
    k = $urandom_range(0, 6);
    repeat (k) begin
      p = $urandom_range(0, DIMENSION - 2);
      send_item(OP_QUERY, SLOT_IN_W'($urandom()), POS_IN_W'(p),
                nudge(sb.query_mem[p], draw_amp()));
    end
    send_item(OP_QUERY, SLOT_IN_W'($urandom()), POS_IN_W'(DIMENSION - 1),
              nudge(sb.query_mem[DIMENSION - 1], draw_amp()));
  endtask

  // Edit a few elements of one slot
  task automatic touch_slot(int unsigned s, bit wild);
    int unsigned k;
    int unsigned p;
    k = $urandom_range(1, 6);
    repeat (k) begin
      p = $urandom_range(0, DIMENSION - 1);
      send_item(OP_LOAD, SLOT_IN_W'(s), POS_IN_W'(p),
                wild ? VALUE_W'($urandom()) : nudge(sb.model_mem[s * DIMENSION + p], draw_amp()));
    end
  endtask

  initial begin
    int roll;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings search no slot, so a lone last query element finds nothing
    send_item(OP_QUERY, '1, POS_IN_W'(DIMENSION - 1), 16'h1234);
    settle();
    write_regs(1'b0, '0, 1'b1, models_setting(4));

    // Four slots: largest, smallest, zero and random elements
    load_slot(0, -1, 0, 16'h7FFF);
    load_slot(1, -1, 0, 16'h8000);
    load_slot(2, -1, 0, 16'h0000);
    load_slot(3, -1, 32767, 16'h0000);
    loaded = 4;
    query_like(1, 0);

    // Zero limit: nothing can match
    settle();
    write_regs(1'b1, '0, 1'b0, '0);
    send_item(OP_QUERY, '0, POS_IN_W'(DIMENSION - 1), 16'h8000);

    // Largest limit with more slots than exist, then with all slots; slot zero hits first
    settle();
    write_regs(1'b1, LIMIT_MAX, 1'b1, models_setting(511));
    send_item(OP_QUERY, '0, POS_IN_W'(DIMENSION - 1), 16'h8000);
    settle();
    write_regs(1'b0, '0, 1'b1, models_setting(MAX_MODELS));
    send_item(OP_QUERY, '1, POS_IN_W'(DIMENSION - 1), 16'h8000);

    // Distance equal to the limit misses, one below it matches
    settle();
    write_regs(1'b1, SUM_W'(1), 1'b1, models_setting(4));
    send_item(OP_QUERY, '0, POS_IN_W'(DIMENSION - 1), 16'h8001);
    settle();
    write_regs(1'b1, SUM_W'(2), 1'b0, '0);
    send_item(OP_QUERY, '0, POS_IN_W'(DIMENSION - 1), 16'h8001);

    // Loads into slots that are never searched
    send_item(OP_LOAD, 8'hFF, POS_IN_W'(DIMENSION - 1), 16'h7FFF);
    send_item(OP_LOAD, 8'h80, 7'd64, 16'h0001);

    // Random phases, each under its own settings
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      steady_in = ($urandom_range(0, 4) == 0);
      write_regs($urandom_range(0, 3) != 0, random_limit(),
                 $urandom_range(0, 2) != 0, models_setting(draw_models()));
      repeat ($urandom_range(3, 8)) begin
        roll = $urandom_range(0, 99);
        if (roll < 8 && loaded < MAX_LOADED) begin
          if ($urandom_range(0, 1) == 0) begin
            load_slot(loaded, -1, 32767, 16'h0000);
          end else begin
            load_slot(loaded, $urandom_range(0, loaded - 1), draw_amp(), 16'h0000);
          end
          loaded++;
        end else if (roll < 25) begin
          touch_slot($urandom_range(0, loaded - 1), 1'b0);
        end else if (roll < 32) begin
          touch_slot($urandom_range(loaded, MAX_MODELS - 1), 1'b1);
        end else if (roll < 45) begin
          query_like($urandom_range(0, loaded - 1), draw_amp());
        end else begin
          touch_query();
        end
      end
    end

    settle();
    sb.close();
    $display("Drove %0d items (%0d loads, %0d queries), %0d register writes, %0d full slots;",
             items_sent, loads_sent, queries_sent, cfg_writes, loaded);
    $display("checked %0d scan results, %0d of them matches.", sb.results, sb.hits);
    if (sb.errors == 0) begin
      $display("descriptor_threshold_match_test: done, clean");
    end else begin
      $display("descriptor_threshold_match_test: done, errors");
    end
    $finish;
  end

endmodule
